[rtl/nearest_neighbor_scale_addr_gen_macros.svh]
// Assertion macros used by the address generator controller RTL.
`ifndef NEAREST_NEIGHBOR_SCALE_ADDR_GEN_MACROS_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDR_GEN_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define NNSA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define NNSA_ASSERT(lbl, prop, msg) \
  `NNSA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/nnsa_pkg.sv]
// Shared types, constants and datapath operation codes for the scaling address generator.
package nnsa_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned OFS_W           = 32;
  localparam int unsigned DIM_W           = 16;
  localparam int unsigned DIV_STEPS       = OFS_W;
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_STEPS);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH      = 3'd0,
    REG_SRC_HEIGHT     = 3'd1,
    REG_X_SRC_FACTOR   = 3'd2,
    REG_X_DEST_FACTOR  = 3'd3,
    REG_Y_SRC_FACTOR   = 3'd4,
    REG_Y_DEST_FACTOR  = 3'd5,
    REG_SRC_ROW_STRIDE = 3'd6,
    REG_DST_ROW_STRIDE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] x_src_factor;
    logic [CFG_W-1:0] x_dest_factor;
    logic [CFG_W-1:0] y_src_factor;
    logic [CFG_W-1:0] y_dest_factor;
    logic [CFG_W-1:0] src_row_stride;
    logic [CFG_W-1:0] dst_row_stride;
  } cfg_t;

  // One datapath action per cycle, issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_XSZ,
    OP_DIV_XDEN,
    OP_SET_DSTW,
    OP_MUL_YSZ,
    OP_DIV_YDEN,
    OP_SET_DSTH,
    OP_DIV_BPP,
    OP_SET_BPP,
    OP_EMIT_RESTART,
    OP_MUL_COL_SW,
    OP_DIV_DSTW,
    OP_MUL_SX_BPP,
    OP_SRC_ADD,
    OP_MUL_ROW_DS,
    OP_DST_SET,
    OP_MUL_COL_BPP,
    OP_DST_ADD,
    OP_EMIT_COPY,
    OP_EMIT_DONE,
    OP_MUL_ROW_SH,
    OP_DIV_DSTH,
    OP_MUL_SY_SS,
    OP_SET_BASE
  } dp_op_e;

  typedef struct packed {
    logic div_busy;
    logic active;
    logic row_wrap;
    logic out_stall;
  } dp_status_t;

endpackage

[rtl/nnsa_in_if.sv]
// Input channel: one restart-or-advance transaction.
interface nnsa_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

[rtl/nnsa_out_if.sv]
// Output channel: one copy descriptor or status transaction.
interface nnsa_out_if
  import nnsa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             copy_valid;
  logic [OFS_W-1:0] src_offset;
  logic [OFS_W-1:0] dst_offset;
  logic             last_copy;
  logic             job_done;
  logic [DIM_W-1:0] dest_width;
  logic [DIM_W-1:0] dest_height;

  modport source (
    output valid, output copy_valid, output src_offset, output dst_offset,
    output last_copy, output job_done, output dest_width, output dest_height,
    input ready
  );
  modport sink (
    input valid, input copy_valid, input src_offset, input dst_offset,
    input last_copy, input job_done, input dest_width, input dest_height,
    output ready
  );
endinterface

[rtl/nnsa_div.sv]
// Radix-2 restoring divider: 32-bit dividend by 16-bit divisor, one bit per cycle.
module nnsa_div
  import nnsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OFS_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic [OFS_W-1:0] quotient_o,
  output logic             busy_o
);

  logic [OFS_W-1:0]     quo_q;
  logic [CFG_W-1:0]     rem_q;
  logic [CFG_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic [CFG_W:0]       rem_sh;
  logic [CFG_W:0]       rem_nx;
  logic                 q_bit;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[OFS_W-1]};
    q_bit  = (rem_sh >= {1'b0, dsr_q});
    rem_nx = q_bit ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  // Control: step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Payload: quotient shifts in from the low end as dividend bits leave the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[OFS_W-2:0], q_bit};
      rem_q <= rem_nx[CFG_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

endmodule

[rtl/nnsa_dp.sv]
// Datapath: job state, shared multiplier and divider, offset accumulators, result register.
module nnsa_dp
  import nnsa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  dp_op_e     op_i,
  output dp_status_t status_o,
  nnsa_out_if.source out_if
);

  localparam logic [COORD_WIDTH-1:0] CoordOne = COORD_WIDTH'(1);

  // Job state
  logic [COORD_WIDTH-1:0] dst_w_q, dst_h_q, col_q, row_q;
  logic [CFG_W-1:0]       bpp_q, byte_q;
  logic [OFS_W-1:0]       base_q;
  logic                   active_q;

  // Work registers
  logic [OFS_W-1:0] prod_q, src_acc_q, dst_acc_q;

  // Result register
  logic             out_valid_q;
  logic             o_copy_q, o_last_q, o_done_q;
  logic [OFS_W-1:0] o_src_q, o_dst_q;
  logic [DIM_W-1:0] o_dw_q, o_dh_q;

  logic [CFG_W-1:0] mul_a, mul_b;
  logic [OFS_W-1:0] mul_p;
  logic [OFS_W-1:0] div_dividend;
  logic [CFG_W-1:0] div_divisor;
  logic             div_start;
  logic [OFS_W-1:0] quot;
  logic             div_busy;
  logic             byte_end, col_end, row_end, last;

  // Multiplier operand selection
  always_comb begin
    unique case (op_i)
      OP_MUL_XSZ:     begin mul_a = cfg_i.src_width;  mul_b = cfg_i.x_dest_factor;  end
      OP_MUL_YSZ:     begin mul_a = cfg_i.src_height; mul_b = cfg_i.y_dest_factor;  end
      OP_MUL_COL_SW:  begin mul_a = CFG_W'(col_q);    mul_b = cfg_i.src_width;      end
      OP_MUL_SX_BPP:  begin mul_a = quot[CFG_W-1:0];  mul_b = bpp_q;                end
      OP_MUL_ROW_DS:  begin mul_a = CFG_W'(row_q);    mul_b = cfg_i.dst_row_stride; end
      OP_MUL_COL_BPP: begin mul_a = CFG_W'(col_q);    mul_b = bpp_q;                end
      OP_MUL_ROW_SH:  begin mul_a = CFG_W'(row_q);    mul_b = cfg_i.src_height;     end
      OP_MUL_SY_SS:   begin mul_a = quot[CFG_W-1:0];  mul_b = cfg_i.src_row_stride; end
      default:        begin mul_a = '0;               mul_b = '0;                   end
    endcase
    mul_p = OFS_W'(mul_a) * OFS_W'(mul_b);
  end

  // Divider operand selection
  always_comb begin
    div_start = 1'b1;
    unique case (op_i)
      OP_DIV_XDEN: begin div_dividend = prod_q; div_divisor = cfg_i.x_src_factor; end
      OP_DIV_YDEN: begin div_dividend = prod_q; div_divisor = cfg_i.y_src_factor; end
      OP_DIV_BPP: begin
        div_dividend = OFS_W'(cfg_i.src_row_stride);
        div_divisor  = cfg_i.src_width;
      end
      OP_DIV_DSTW: begin div_dividend = prod_q; div_divisor = CFG_W'(dst_w_q); end
      OP_DIV_DSTH: begin div_dividend = prod_q; div_divisor = CFG_W'(dst_h_q); end
      default: begin
        div_start    = 1'b0;
        div_dividend = prod_q;
        div_divisor  = CFG_W'(dst_w_q);
      end
    endcase
  end

  nnsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quot),
    .busy_o     (div_busy)
  );

  // End-of-pixel, end-of-row and end-of-job conditions
  assign byte_end = (byte_q >= (bpp_q - CFG_W'(1)));
  assign col_end  = (col_q >= (dst_w_q - CoordOne));
  assign row_end  = (row_q >= (dst_h_q - CoordOne));
  assign last     = byte_end && col_end && row_end;

  // Job state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_w_q  <= '0;
      dst_h_q  <= '0;
      bpp_q    <= CFG_W'(1);
      col_q    <= '0;
      row_q    <= '0;
      byte_q   <= '0;
      base_q   <= '0;
      active_q <= 1'b0;
    end else begin
      unique case (op_i)
        OP_SET_DSTW: begin
          dst_w_q <= (cfg_i.x_src_factor == '0) ? '0 : quot[COORD_WIDTH-1:0];
        end
        OP_SET_DSTH: begin
          dst_h_q <= (cfg_i.y_src_factor == '0) ? '0 : quot[COORD_WIDTH-1:0];
        end
        OP_SET_BPP: begin
          bpp_q    <= ((cfg_i.src_width == '0) || (quot[CFG_W-1:0] == '0)) ?
                      CFG_W'(1) : quot[CFG_W-1:0];
          col_q    <= '0;
          row_q    <= '0;
          byte_q   <= '0;
          base_q   <= '0;
          active_q <= (dst_w_q != '0) && (dst_h_q != '0);
        end
        OP_EMIT_COPY: begin
          if (last) begin
            active_q <= 1'b0;
          end else if (!byte_end) begin
            byte_q <= byte_q + CFG_W'(1);
          end else begin
            byte_q <= '0;
            if (!col_end) begin
              col_q <= col_q + CoordOne;
            end else begin
              col_q <= '0;
              row_q <= row_q + CoordOne;
            end
          end
        end
        OP_SET_BASE: base_q <= prod_q;
        default: ;
      endcase
    end
  end

  // Product and offset accumulators
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_MUL_XSZ, OP_MUL_YSZ, OP_MUL_COL_SW, OP_MUL_SX_BPP, OP_MUL_ROW_DS,
      OP_MUL_COL_BPP, OP_MUL_ROW_SH, OP_MUL_SY_SS: prod_q <= mul_p;
      OP_SRC_ADD: src_acc_q <= base_q + prod_q;
      OP_DST_SET: dst_acc_q <= prod_q;
      OP_DST_ADD: dst_acc_q <= dst_acc_q + prod_q;
      default: ;
    endcase
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_i == OP_EMIT_COPY || op_i == OP_EMIT_RESTART || op_i == OP_EMIT_DONE) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_EMIT_COPY: begin
        o_copy_q <= 1'b1;
        o_src_q  <= src_acc_q + OFS_W'(byte_q);
        o_dst_q  <= dst_acc_q + OFS_W'(byte_q);
        o_last_q <= last;
        o_done_q <= 1'b0;
        o_dw_q   <= DIM_W'(dst_w_q);
        o_dh_q   <= DIM_W'(dst_h_q);
      end
      OP_EMIT_RESTART, OP_EMIT_DONE: begin
        o_copy_q <= 1'b0;
        o_src_q  <= '0;
        o_dst_q  <= '0;
        o_last_q <= 1'b0;
        o_done_q <= (op_i == OP_EMIT_DONE) ? 1'b1 : !active_q;
        o_dw_q   <= DIM_W'(dst_w_q);
        o_dh_q   <= DIM_W'(dst_h_q);
      end
      default: ;
    endcase
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.copy_valid  = o_copy_q;
  assign out_if.src_offset  = o_src_q;
  assign out_if.dst_offset  = o_dst_q;
  assign out_if.last_copy   = o_last_q;
  assign out_if.job_done    = o_done_q;
  assign out_if.dest_width  = o_dw_q;
  assign out_if.dest_height = o_dh_q;

  assign status_o.div_busy  = div_busy;
  assign status_o.active    = active_q;
  assign status_o.row_wrap  = byte_end && col_end && !row_end;
  assign status_o.out_stall = out_valid_q && !out_if.ready;

endmodule

[rtl/nnsa_ctrl.sv]
// Controller: sequences datapath operations for restart, copy and done transactions.
`include "nearest_neighbor_scale_addr_gen_macros.svh"

module nnsa_ctrl
  import nnsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  nnsa_in_if.sink    in_if,
  input  dp_status_t status_i,
  output dp_op_e     op_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    // restart: sizes and bytes per pixel
    S_XMUL, S_XDIV, S_XWAIT, S_XSET,
    S_YMUL, S_YDIV, S_YWAIT, S_YSET,
    S_BDIV, S_BWAIT, S_BSET, S_RST_W, S_RST_EMIT,
    // copy: source column, then both offsets
    S_CMUL, S_CDIV, S_CWAIT, S_SXMUL, S_SRCADD,
    S_RDMUL, S_DSTSET, S_CBMUL, S_DSTADD, S_CP_W, S_CP_EMIT,
    // new source row base
    S_RBMUL, S_RBDIV, S_RBWAIT, S_RBMUL2, S_RBSET,
    // advance with no job
    S_DN_W, S_DN_EMIT
  } state_e;

  state_e state_q, state_d;
  dp_op_e op_q;
  logic   in_fire;

  function automatic dp_op_e op_for(state_e st);
    dp_op_e op;
    unique case (st)
      S_XMUL:     op = OP_MUL_XSZ;
      S_XDIV:     op = OP_DIV_XDEN;
      S_XSET:     op = OP_SET_DSTW;
      S_YMUL:     op = OP_MUL_YSZ;
      S_YDIV:     op = OP_DIV_YDEN;
      S_YSET:     op = OP_SET_DSTH;
      S_BDIV:     op = OP_DIV_BPP;
      S_BSET:     op = OP_SET_BPP;
      S_RST_EMIT: op = OP_EMIT_RESTART;
      S_CMUL:     op = OP_MUL_COL_SW;
      S_CDIV:     op = OP_DIV_DSTW;
      S_SXMUL:    op = OP_MUL_SX_BPP;
      S_SRCADD:   op = OP_SRC_ADD;
      S_RDMUL:    op = OP_MUL_ROW_DS;
      S_DSTSET:   op = OP_DST_SET;
      S_CBMUL:    op = OP_MUL_COL_BPP;
      S_DSTADD:   op = OP_DST_ADD;
      S_CP_EMIT:  op = OP_EMIT_COPY;
      S_RBMUL:    op = OP_MUL_ROW_SH;
      S_RBDIV:    op = OP_DIV_DSTH;
      S_RBMUL2:   op = OP_MUL_SY_SS;
      S_RBSET:    op = OP_SET_BASE;
      S_DN_EMIT:  op = OP_EMIT_DONE;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

  assign in_fire = in_if.valid && in_if.ready;

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          priority if (in_if.restart) state_d = S_XMUL;
          else if (status_i.active)   state_d = S_CMUL;
          else                        state_d = S_DN_W;
        end
      end
      S_XMUL:     state_d = S_XDIV;
      S_XDIV:     state_d = S_XWAIT;
      S_XWAIT:    if (!status_i.div_busy) state_d = S_XSET;
      S_XSET:     state_d = S_YMUL;
      S_YMUL:     state_d = S_YDIV;
      S_YDIV:     state_d = S_YWAIT;
      S_YWAIT:    if (!status_i.div_busy) state_d = S_YSET;
      S_YSET:     state_d = S_BDIV;
      S_BDIV:     state_d = S_BWAIT;
      S_BWAIT:    if (!status_i.div_busy) state_d = S_BSET;
      S_BSET:     state_d = S_RST_W;
      S_RST_W:    if (!status_i.out_stall) state_d = S_RST_EMIT;
      S_RST_EMIT: state_d = S_IDLE;
      S_CMUL:     state_d = S_CDIV;
      S_CDIV:     state_d = S_CWAIT;
      S_CWAIT:    if (!status_i.div_busy) state_d = S_SXMUL;
      S_SXMUL:    state_d = S_SRCADD;
      S_SRCADD:   state_d = S_RDMUL;
      S_RDMUL:    state_d = S_DSTSET;
      S_DSTSET:   state_d = S_CBMUL;
      S_CBMUL:    state_d = S_DSTADD;
      S_DSTADD:   state_d = S_CP_W;
      S_CP_W:     if (!status_i.out_stall) state_d = S_CP_EMIT;
      S_CP_EMIT:  state_d = status_i.row_wrap ? S_RBMUL : S_IDLE;
      S_RBMUL:    state_d = S_RBDIV;
      S_RBDIV:    state_d = S_RBWAIT;
      S_RBWAIT:   if (!status_i.div_busy) state_d = S_RBMUL2;
      S_RBMUL2:   state_d = S_RBSET;
      S_RBSET:    state_d = S_IDLE;
      S_DN_W:     if (!status_i.out_stall) state_d = S_DN_EMIT;
      S_DN_EMIT:  state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // State and registered operation code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NONE;
    end else begin
      state_q <= state_d;
      op_q    <= op_for(state_d);
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign op_o        = op_q;

  `NNSA_ASSERT(a_div_runs_after_start, (op_q == OP_DIV_XDEN || op_q == OP_DIV_YDEN || op_q == OP_DIV_BPP || op_q == OP_DIV_DSTW || op_q == OP_DIV_DSTH) |=> status_i.div_busy, "divider not busy after start")
  `NNSA_ASSERT(a_emit_slot_free, (op_q == OP_EMIT_COPY || op_q == OP_EMIT_RESTART || op_q == OP_EMIT_DONE) |-> !status_i.out_stall, "result written over a pending transaction")
  `NNSA_ASSERT(a_accept_leaves_idle, in_fire |=> (state_q != S_IDLE), "accepted transaction not started")

endmodule

[rtl/nearest_neighbor_scale_addr_gen.sv]
// Restart transaction: the result follows three divisions after acceptance.
// Copy transaction: the result follows one division; at the end of a destination row
// the next transaction is taken only after a further division for the new source row base.
// Done transaction with no job: the result is emitted without any division.
// One transaction at a time; throughput is set by the shared 32-step serial divider.
// Asynchronous active-low reset clears the job and restores the configuration defaults.
module nearest_neighbor_scale_addr_gen
  import nnsa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nnsa_in_if.sink              in_if,
  nnsa_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t       cfg_q;
  dp_op_e     op;
  dp_status_t status;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width      <= '0;
      cfg_q.src_height     <= '0;
      cfg_q.x_src_factor   <= CFG_W'(1);
      cfg_q.x_dest_factor  <= CFG_W'(1);
      cfg_q.y_src_factor   <= CFG_W'(1);
      cfg_q.y_dest_factor  <= CFG_W'(1);
      cfg_q.src_row_stride <= '0;
      cfg_q.dst_row_stride <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SRC_WIDTH:      cfg_q.src_width      <= cfg_wdata_i;
        REG_SRC_HEIGHT:     cfg_q.src_height     <= cfg_wdata_i;
        REG_X_SRC_FACTOR:   cfg_q.x_src_factor   <= cfg_wdata_i;
        REG_X_DEST_FACTOR:  cfg_q.x_dest_factor  <= cfg_wdata_i;
        REG_Y_SRC_FACTOR:   cfg_q.y_src_factor   <= cfg_wdata_i;
        REG_Y_DEST_FACTOR:  cfg_q.y_dest_factor  <= cfg_wdata_i;
        REG_SRC_ROW_STRIDE: cfg_q.src_row_stride <= cfg_wdata_i;
        REG_DST_ROW_STRIDE: cfg_q.dst_row_stride <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  nnsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_if    (in_if),
    .status_i (status),
    .op_o     (op)
  );

  nnsa_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .op_i     (op),
    .status_o (status),
    .out_if   (out_if)
  );

endmodule

[dv/nearest_neighbor_scale_addr_gen_tb.sv]
// Self-checking testbench for the nearest-neighbor scaling address generator.
module nearest_neighbor_scale_addr_gen_tb;
  import nnsa_pkg::*;

  localparam int  SETTLE_CYCLES  = 64;         // covers the row base update after a row end
  localparam int  MAX_JOB_COPIES = 96;
  localparam bit  RESTART        = 1'b1;
  localparam bit  ADVANCE        = 1'b0;
  localparam time TIMEOUT        = 64'd60_000_000;

  // Result fields of one output transaction
  typedef struct packed {
    logic             copy_valid;
    logic [OFS_W-1:0] src_offset;
    logic [OFS_W-1:0] dst_offset;
    logic             last_copy;
    logic             job_done;
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
  } xfer_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  nnsa_in_if  in_ch ();
  nnsa_out_if out_ch ();

  nearest_neighbor_scale_addr_gen i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Stimulus and scoreboard state
  bit    restart_q [$];
  xfer_t expected_xfers [$];
  int    xact_issued;
  int    xact_accepted;
  int    items_queued;
  int    err_cnt;
  int    snd_idle_pct;
  int    rcv_idle_pct;

  // Predictor copy of the registers and of the job state
  logic [CFG_W-1:0] scale_regs [8];
  logic [DIM_W-1:0] job_w, job_h, pix_bytes;
  logic [15:0]      col_idx, row_idx, byte_idx;
  logic [31:0]      src_base;
  bit               job_active;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [DIM_W-1:0] scaled_size(logic [15:0] size, logic [15:0] num,
                                                   logic [15:0] den);
    if (den == '0) return '0;
    return DIM_W'((64'(size) * 64'(num)) / 64'(den));
  endfunction

  // Expected result of one accepted transaction; advances the predicted job state
  function automatic xfer_t next_xfer(bit restart);
    xfer_t       r;
    logic [31:0] sx;
    logic [31:0] sy;
    bit          fin;
    r = '0;
    if (restart) begin
      job_w = scaled_size(scale_regs[REG_SRC_WIDTH], scale_regs[REG_X_DEST_FACTOR],
                          scale_regs[REG_X_SRC_FACTOR]);
      job_h = scaled_size(scale_regs[REG_SRC_HEIGHT], scale_regs[REG_Y_DEST_FACTOR],
                          scale_regs[REG_Y_SRC_FACTOR]);
      pix_bytes = (scale_regs[REG_SRC_WIDTH] != '0) ?
                  scale_regs[REG_SRC_ROW_STRIDE] / scale_regs[REG_SRC_WIDTH] : 16'd1;
      if (pix_bytes == '0) pix_bytes = 16'd1;
      col_idx    = '0;
      row_idx    = '0;
      byte_idx   = '0;
      src_base   = '0;
      job_active = (job_w != '0) && (job_h != '0);
      r.job_done = !job_active;
    end else if (!job_active) begin
      r.job_done = 1'b1;
    end else begin
      // source column and sizes are taken live; bytes per pixel stays latched
      sx = 32'((64'(col_idx) * 64'(scale_regs[REG_SRC_WIDTH])) / 64'(job_w));
      r.copy_valid = 1'b1;
      r.src_offset = src_base + sx * 32'(pix_bytes) + 32'(byte_idx);
      r.dst_offset = 32'(row_idx) * 32'(scale_regs[REG_DST_ROW_STRIDE]) +
                     32'(col_idx) * 32'(pix_bytes) + 32'(byte_idx);
      fin = (byte_idx + 16'd1 >= pix_bytes) && (col_idx + 16'd1 >= job_w) &&
            (row_idx + 16'd1 >= job_h);
      r.last_copy = fin;
      if (fin) begin
        job_active = 1'b0;
      end else if (byte_idx + 16'd1 < pix_bytes) begin
        byte_idx = byte_idx + 16'd1;
      end else begin
        byte_idx = '0;
        if (col_idx + 16'd1 < job_w) begin
          col_idx = col_idx + 16'd1;
        end else begin
          col_idx  = '0;
          row_idx  = row_idx + 16'd1;
          sy       = 32'((64'(row_idx) * 64'(scale_regs[REG_SRC_HEIGHT])) / 64'(job_h));
          src_base = sy * 32'(scale_regs[REG_SRC_ROW_STRIDE]);
        end
      end
    end
    r.dest_width  = job_w;
    r.dest_height = job_h;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Driver: input transactions and receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin : drive
    bit launch;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
      if (xact_issued == xact_accepted) begin
        launch = (restart_q.size() != 0) && ($urandom_range(99) >= snd_idle_pct);
        if (launch) begin
          in_ch.restart <= restart_q.pop_front();
          xact_issued   <= xact_issued + 1;
        end
        in_ch.valid <= launch;
      end
    end
  end

  // Monitor: predict on each accepted input, compare each accepted result
  always @(posedge clk) begin : observe
    xfer_t want;
    xfer_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_xfers.push_back(next_xfer(in_ch.restart));
        xact_accepted <= xact_accepted + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.copy_valid, out_ch.src_offset, out_ch.dst_offset, out_ch.last_copy,
                out_ch.job_done, out_ch.dest_width, out_ch.dest_height};
        if (expected_xfers.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
        end else begin
          want = expected_xfers.pop_front();
          check_field("copy_valid", 32'(want.copy_valid), 32'(got.copy_valid));
          check_field("src_offset", want.src_offset, got.src_offset);
          check_field("dst_offset", want.dst_offset, got.dst_offset);
          check_field("last_copy", 32'(want.last_copy), 32'(got.last_copy));
          check_field("job_done", 32'(want.job_done), 32'(got.job_done));
          check_field("dest_width", 32'(want.dest_width), 32'(got.dest_width));
          check_field("dest_height", 32'(want.dest_height), 32'(got.dest_height));
        end
      end
    end
  end

  task automatic queue_item(bit restart);
    restart_q.push_back(restart);
    items_queued++;
  endtask

  // Wait until every queued transaction has its result, then let the block finish
  task automatic settle();
    while (restart_q.size() != 0 || xact_issued != xact_accepted ||
           expected_xfers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we          <= 1'b0;
    scale_regs[idx] = val;
  endtask

  task automatic load_cfg(cfg_t c);
    settle();
    write_reg(REG_SRC_WIDTH, c.src_width);
    write_reg(REG_SRC_HEIGHT, c.src_height);
    write_reg(REG_X_SRC_FACTOR, c.x_src_factor);
    write_reg(REG_X_DEST_FACTOR, c.x_dest_factor);
    write_reg(REG_Y_SRC_FACTOR, c.y_src_factor);
    write_reg(REG_Y_DEST_FACTOR, c.y_dest_factor);
    write_reg(REG_SRC_ROW_STRIDE, c.src_row_stride);
    write_reg(REG_DST_ROW_STRIDE, c.dst_row_stride);
  endtask

  // Mostly tiny sizes, with zero and full-range values mixed in
  function automatic logic [15:0] pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 75) return 16'($urandom_range(1, 6));
    if (sel < 80) return 16'hFFFF;
    return 16'($urandom_range(7, 65535));
  endfunction

  // Scale factors that keep the destination small for large sources
  function automatic void pick_factors(input logic [15:0] dim, output logic [15:0] num,
                                       output logic [15:0] den);
    int sel;
    sel = $urandom_range(99);
    if (sel < 5) begin
      num = 16'($urandom);
      den = '0;
    end else if (sel < 10) begin
      num = 16'($urandom);
      den = 16'($urandom);
    end else if (dim > 6) begin
      num = 16'd1;
      den = 16'(dim / $urandom_range(1, 5));
    end else begin
      num = 16'($urandom_range(1, 4));
      den = 16'($urandom_range(1, 4));
    end
  endfunction

  task automatic random_job();
    cfg_t        c;
    logic [15:0] w, h, bpp;
    longint      copies;
    int          cut, sel;
    c.src_width  = pick_dim();
    c.src_height = pick_dim();
    pick_factors(c.src_width, c.x_dest_factor, c.x_src_factor);
    pick_factors(c.src_height, c.y_dest_factor, c.y_src_factor);
    c.src_row_stride = ($urandom_range(99) < 70) ?
        16'(c.src_width * $urandom_range(1, 3) + $urandom_range(0, 1)) : 16'($urandom);
    w   = scaled_size(c.src_width, c.x_dest_factor, c.x_src_factor);
    h   = scaled_size(c.src_height, c.y_dest_factor, c.y_src_factor);
    bpp = (c.src_width != '0) ? c.src_row_stride / c.src_width : 16'd1;
    if (bpp == '0) bpp = 16'd1;
    c.dst_row_stride = ($urandom_range(99) < 60) ?
        16'(w * bpp + $urandom_range(0, 2)) : 16'($urandom);
    copies = longint'(w) * h * bpp;
    load_cfg(c);
    sel = $urandom_range(99);
    if (copies > MAX_JOB_COPIES) begin
      // oversized job: a few copies, then abandoned by the next restart
      queue_item(RESTART);
      repeat ($urandom_range(1, 12)) queue_item(ADVANCE);
    end else if (sel < 15 && copies >= 2) begin
      // live registers rewritten in the middle of a job
      cut = $urandom_range(1, int'(copies) - 1);
      queue_item(RESTART);
      repeat (cut) queue_item(ADVANCE);
      settle();
      write_reg(REG_SRC_WIDTH, pick_dim());
      write_reg(REG_SRC_HEIGHT, pick_dim());
      write_reg(REG_SRC_ROW_STRIDE, 16'($urandom));
      write_reg(REG_DST_ROW_STRIDE, 16'($urandom));
      repeat (int'(copies) - cut + $urandom_range(0, 2)) queue_item(ADVANCE);
    end else if (sel < 25) begin
      // noise: restarts scattered through the stream
      repeat ($urandom_range(2, 10))
        queue_item(($urandom_range(99) < 30) ? RESTART : ADVANCE);
    end else begin
      queue_item(RESTART);
      repeat (int'(copies) + $urandom_range(0, 2)) queue_item(ADVANCE);
    end
  endtask

  // Main sequence: reset, directed jobs, then random jobs over three idling phases
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = REG_SRC_WIDTH;
    cfg_wdata    = '0;
    scale_regs   = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0};
    job_w        = '0;
    job_h        = '0;
    pix_bytes    = 16'd1;
    col_idx      = '0;
    row_idx      = '0;
    byte_idx     = '0;
    src_base     = '0;
    job_active   = 1'b0;
    snd_idle_pct = 22;
    rcv_idle_pct = 76;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // advance with no job, then a restart on the reset sizes (empty job)
    queue_item(ADVANCE);
    queue_item(RESTART);
    queue_item(ADVANCE);
    // field order: src w/h, x den/num, y den/num, src/dst stride
    // upscaled row, two bytes per pixel, runs to its last copy
    load_cfg('{16'd2, 16'd3, 16'd2, 16'd3, 16'd2, 16'd1, 16'd4, 16'd7});
    queue_item(RESTART);
    repeat (7) queue_item(ADVANCE);
    // zero horizontal denominator
    load_cfg('{16'd5, 16'd5, 16'd0, 16'd3, 16'd1, 16'd1, 16'd5, 16'd5});
    queue_item(RESTART);
    repeat (2) queue_item(ADVANCE);
    // full-range registers: width wraps to one, height stays at its maximum
    load_cfg('{16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    queue_item(RESTART);
    repeat (3) queue_item(ADVANCE);
    // width overflow down to zero
    load_cfg('{16'h8000, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd0, 16'd0});
    queue_item(RESTART);
    // stride below the width: bytes per pixel clamps to one
    load_cfg('{16'd3, 16'd1, 16'd3, 16'd1, 16'd1, 16'd1, 16'd2, 16'd0});
    queue_item(RESTART);
    repeat (2) queue_item(ADVANCE);
    // restart while a job is still running
    load_cfg('{16'd2, 16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd2});
    queue_item(RESTART);
    queue_item(ADVANCE);
    queue_item(RESTART);
    queue_item(ADVANCE);

    while (items_queued < 520) random_job();
    settle();
    snd_idle_pct = 76;
    rcv_idle_pct = 22;
    while (items_queued < 1040) random_job();
    settle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (items_queued < 1550) random_job();

    settle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/nnsa_pkg.sv
rtl/nnsa_in_if.sv
rtl/nnsa_out_if.sv
rtl/nnsa_div.sv
rtl/nnsa_dp.sv
rtl/nnsa_ctrl.sv
rtl/nearest_neighbor_scale_addr_gen.sv
dv/nearest_neighbor_scale_addr_gen_tb.sv
